FILE: rtl/core/ipe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipe_pkg
// Shared types, widths and operator codes for the infix evaluator.
// ----------------------------------------------------------------------------
package ipe_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int TDATA_W      = 40;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  start;
    op_t   op;
    word_t lhs;
    word_t rhs;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    logic  div_zero;
    word_t value;
  } alu_rsp_t;

  // multiply and divide bind tighter than add and subtract
  function automatic logic prec_hi(input op_t op);
    prec_hi = (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/infix_precedence_evaluator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_precedence_evaluator_top
// Integer infix expression evaluator over a token stream, two-stack method.
// ----------------------------------------------------------------------------
// Input channel s_*: one token per request. tuser = is_number; tlast marks
// the final token; tdata carries number_value and operator_code.
// Output channel m_*: one request per expression, issued after its last token,
// carrying the wrapped 32-bit value and the divide-by-zero and malformed flags.
// Sequencing: a number token is pushed as it is taken. An operator token is
// taken, compared against the operator stack top (fetch, decide) and pushed;
// before the push, each reduction runs in the shared unit: add, subtract and
// multiply directly, divide one quotient bit per cycle unless the divisor is
// zero; an underflowing reduction pops the operator and sets the malformed flag.
// The last token then drains the operator stack the same way, and the result
// is then loaded in the result state. Worst case is set by STACK_DEPTH chained
// divides through the shared unit.
// s_tready is high only while the sequencer is idle and out of reset.
// Reset empties both stacks, clears both flags and drops any pending result.
// A stalled output holds its result; the next tokens are still taken, and a
// following result waits until the held one has been taken.
// ----------------------------------------------------------------------------
module infix_precedence_evaluator_top
  import ipe_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,   // [31:0] number_value, [33:32] operator_code
  input  wire logic               s_tuser,   // is_number
  input  wire logic               s_tlast,   // last_token
  output      logic               m_tvalid,
  input  wire logic               m_tready,
  output      logic [TDATA_W-1:0] m_tdata    // [31:0] result_value, [32] div_zero_seen,
                                             // [33] malformed
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]   state;
  logic [CW-1:0] opnd_cnt;
  logic [CW-1:0] oper_cnt;
  word_t        tos;
  op_t          cur_op;
  logic         cur_last;
  logic         mode_end;
  logic         dz_flag;
  logic         err_flag;
  logic         out_valid;
  logic [TDATA_W-1:0] out_data;

  word_t        opnd_mem [STACK_DEPTH];
  op_t          oper_mem [STACK_DEPTH];
  word_t        opnd_rd;
  op_t          oper_rd;

  logic         s_fire;
  logic         out_free;
  logic [CW-1:0] opnd_m1;
  logic [CW-1:0] opnd_m2;
  logic [CW-1:0] oper_m1;
  logic         opnd_full;
  logic         oper_full;
  logic         push_now;
  logic         opnd_we;
  logic [AW-1:0] opnd_waddr;
  word_t        opnd_wdata;
  logic         oper_we;
  alu_req_t     req;
  alu_rsp_t     rsp;

  assign s_tready = (state == S_IDLE) && !rst;
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    opnd_m1   = opnd_cnt - CW'(1);
    opnd_m2   = opnd_cnt - CW'(2);
    oper_m1   = oper_cnt - CW'(1);
    opnd_full = opnd_cnt >= CW'(STACK_DEPTH);
    oper_full = oper_cnt >= CW'(STACK_DEPTH);
    push_now  = !mode_end && ((oper_cnt == '0) || (!prec_hi(oper_rd) && prec_hi(cur_op)));

    opnd_we    = (s_fire && s_tuser && !opnd_full) || ((state == S_EXEC) && rsp.done);
    opnd_waddr = (state == S_IDLE) ? opnd_cnt[AW-1:0] : opnd_m2[AW-1:0];
    opnd_wdata = (state == S_IDLE) ? s_tdata[DATA_W-1:0] : rsp.value;
    oper_we    = (state == S_DECIDE) && push_now && !oper_full;

    req.start = (state == S_DECIDE) && !push_now && (oper_cnt != '0)
                && (opnd_cnt >= CW'(2));
    req.op    = oper_rd;
    req.lhs   = opnd_rd;
    req.rhs   = tos;
  end

  always_ff @(posedge clk) begin
    if (opnd_we) begin
      opnd_mem[opnd_waddr] <= opnd_wdata;
    end
    if (oper_we) begin
      oper_mem[oper_cnt[AW-1:0]] <= cur_op;
    end
    opnd_rd <= opnd_mem[opnd_m2[AW-1:0]];
    oper_rd <= oper_mem[oper_m1[AW-1:0]];
  end

  ipe_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      opnd_cnt  <= '0;
      oper_cnt  <= '0;
      dz_flag   <= 1'b0;
      err_flag  <= 1'b0;
      mode_end  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready && !((state == S_RESULT) && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            cur_op   <= s_tdata[DATA_W +: OP_W];
            cur_last <= s_tlast;
            if (s_tuser) begin
              if (!opnd_full) begin
                opnd_cnt <= opnd_cnt + CW'(1);
                tos      <= s_tdata[DATA_W-1:0];
              end else begin
                err_flag <= 1'b1;
              end
              mode_end <= 1'b1;
              state    <= s_tlast ? S_FETCH : S_IDLE;
            end else begin
              mode_end <= 1'b0;
              state    <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (push_now) begin
            if (!oper_full) begin
              oper_cnt <= oper_cnt + CW'(1);
            end else begin
              err_flag <= 1'b1;
            end
            mode_end <= 1'b1;
            state    <= cur_last ? S_FETCH : S_IDLE;
          end else if (oper_cnt == '0) begin
            state <= S_RESULT;
          end else begin
            oper_cnt <= oper_m1;
            if (opnd_cnt < CW'(2)) begin
              err_flag <= 1'b1;
              state    <= S_FETCH;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (rsp.done) begin
            opnd_cnt <= opnd_m1;
            tos      <= rsp.value;
            dz_flag  <= dz_flag | rsp.div_zero;
            state    <= S_FETCH;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= {{(TDATA_W - DATA_W - 2){1'b0}},
                          err_flag | (opnd_cnt == '0), dz_flag,
                          (opnd_cnt == '0) ? word_t'(0) : tos};
            opnd_cnt  <= '0;
            oper_cnt  <= '0;
            dz_flag   <= 1'b0;
            err_flag  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_opnd_bound: assert property (@(posedge clk) disable iff (rst)
    opnd_cnt <= CW'(STACK_DEPTH))
    else $error("operand count beyond stack depth");

  a_oper_bound: assert property (@(posedge clk) disable iff (rst)
    oper_cnt <= CW'(STACK_DEPTH))
    else $error("operator count beyond stack depth");

  a_done_in_exec: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_EXEC))
    else $error("arithmetic unit finished outside execute");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESULT) && out_free) |=> (opnd_cnt == '0) && (oper_cnt == '0)
                                          && m_tvalid)
    else $error("stacks not cleared after result");

  a_start_with_operands: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (opnd_cnt >= CW'(2)) && (oper_cnt != '0))
    else $error("reduction started without operands");

endmodule
`default_nettype wire

FILE: rtl/core/ipe_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipe_alu
// Shared arithmetic unit: add, subtract and multiply registered directly from the request;
// truncating signed divide by a restoring shift-subtract loop, one bit per cycle.
// ----------------------------------------------------------------------------
module ipe_alu
  import ipe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  localparam int IW = $clog2(DATA_W);

  logic              busy;
  logic [IW-1:0]     iter;
  logic              neg;
  word_t             quo;
  word_t             rem;
  word_t             divisor;
  logic              done;
  logic              dz;
  word_t             value;

  word_t             mag_a;
  word_t             mag_b;
  word_t             rem_sh;
  logic              take;
  word_t             rem_next;
  word_t             quo_next;
  word_t             prod;

  always_comb begin
    mag_a    = req.lhs[DATA_W-1] ? (~req.lhs + 1'b1) : req.lhs;
    mag_b    = req.rhs[DATA_W-1] ? (~req.rhs + 1'b1) : req.rhs;
    rem_sh   = {rem[DATA_W-2:0], quo[DATA_W-1]};
    take     = rem_sh >= divisor;
    rem_next = take ? (rem_sh - divisor) : rem_sh;
    quo_next = {quo[DATA_W-2:0], take};
    prod     = req.lhs * req.rhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem  <= rem_next;
        quo  <= quo_next;
        iter <= iter + 1'b1;
        if (iter == IW'(DATA_W - 1)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          value <= neg ? (~quo_next + 1'b1) : quo_next;
        end
      end else if (req.start) begin
        dz <= 1'b0;
        case (req.op)
          OP_ADD: begin
            value <= req.lhs + req.rhs;
            done  <= 1'b1;
          end
          OP_SUB: begin
            value <= req.lhs - req.rhs;
            done  <= 1'b1;
          end
          OP_MUL: begin
            value <= prod;
            done  <= 1'b1;
          end
          default: begin
            if (req.rhs == '0) begin
              value <= '0;
              dz    <= 1'b1;
              done  <= 1'b1;
            end else begin
              busy    <= 1'b1;
              iter    <= '0;
              neg     <= req.lhs[DATA_W-1] ^ req.rhs[DATA_W-1];
              quo     <= mag_a;
              rem     <= '0;
              divisor <= mag_b;
            end
          end
        endcase
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.div_zero = dz;
  assign rsp.value    = value;

endmodule
`default_nettype wire
